@@ hw/rtl/vmac_pkg.sv @@
// ----------------------------------------------------------------------------
// vmac_pkg
// shared types, opcodes and helpers of the eight-lane vector mac unit
// ----------------------------------------------------------------------------
package vmac_pkg;

	localparam int unsigned LANE_W = 16;
	localparam int unsigned ACC_W  = 48;
	localparam int unsigned NLANES = 8;

	typedef enum logic [3:0] {
		OP_AND   = 4'd0,
		OP_NAND  = 4'd1,
		OP_OR    = 4'd2,
		OP_NOR   = 4'd3,
		OP_XOR   = 4'd4,
		OP_NXOR  = 4'd5,
		OP_MACF  = 4'd6,
		OP_MACU  = 4'd7,
		OP_MADH  = 4'd8,
		OP_MADL  = 4'd9,
		OP_MADM  = 4'd10,
		OP_MADN  = 4'd11,
		OP_WRITE = 4'd12
	} op_t;

	typedef logic [LANE_W-1:0] lane_t;
	typedef lane_t [NLANES-1:0] vec_t;
	typedef logic [ACC_W-1:0] acc_t;

	// lane of the second source feeding lane i
	function automatic logic [2:0] pick_lane(input logic [3:0] e, input logic [2:0] i);
		logic [2:0] r;
		r = i;
		unique case (e)
			4'd2: r = {i[2:1], 1'b0};
			4'd3: r = {i[2:1], 1'b1};
			4'd4: r = {i[2], 2'b00};
			4'd5: r = {i[2], 2'b01};
			4'd6: r = {i[2], 2'b10};
			4'd7: r = {i[2], 2'b11};
			4'd0, 4'd1: r = i;
			default: r = e[2:0];
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/vmac_lane.sv @@
// ----------------------------------------------------------------------------
// vmac_lane
// one lane: logic op or multiply-accumulate with clamp, combinational
// ----------------------------------------------------------------------------
module vmac_lane
	import vmac_pkg::*;
(
	input  logic [3:0] op,
	input  lane_t      a,
	input  lane_t      b,
	input  acc_t       acc,
	output acc_t       acc_nxt,
	output lane_t      res
);

	logic signed [16:0] ax, bx;
	logic signed [33:0] prod;
	acc_t add, sum;
	logic [15:0] hi, md;
	logic in_rng, neg;

	always_comb begin
		ax = {(op == OP_MADN || op == OP_MADL) ? 1'b0 : a[15], a};
		bx = {(op == OP_MADM || op == OP_MADL) ? 1'b0 : b[15], b};
		prod = ax * bx;
		unique case (op)
			OP_MACF, OP_MACU: add = acc_t'({{13{prod[33]}}, prod, 1'b0});
			OP_MADH: add = {prod[31:0], 16'h0000};
			OP_MADL: add = {32'h0, prod[31:16]};
			default: add = {{14{prod[33]}}, prod};
		endcase
		sum = acc + add;
		hi = sum[47:32];
		md = sum[31:16];
		neg = hi[15];
		in_rng = hi == {16{md[15]}};
		acc_nxt = sum;
		res = '0;
		unique case (op)
			OP_AND:  res = a & b;
			OP_NAND: res = ~(a & b);
			OP_OR:   res = a | b;
			OP_NOR:  res = ~(a | b);
			OP_XOR:  res = a ^ b;
			OP_NXOR: res = ~(a ^ b);
			OP_MACU: res = neg ? 16'h0000 : (in_rng ? md : 16'hffff);
			OP_MADL, OP_MADN: res = in_rng ? sum[15:0] : (neg ? 16'h0000 : 16'hffff);
			OP_MACF, OP_MADH, OP_MADM: res = in_rng ? md : (neg ? 16'h8000 : 16'h7fff);
			default: res = '0;
		endcase
		if (op <= OP_NXOR)
			acc_nxt = {acc[47:16], res};
	end

endmodule

@@ hw/rtl/vector_mac_unit_8x16_top.sv @@
// ----------------------------------------------------------------------------
// vector_mac_unit_8x16_top
// eight-lane 16-bit vector logic and multiply-accumulate unit
// ----------------------------------------------------------------------------
// an accepted word passes the input register, then the result register;
// one word per cycle while the result register is not stalled.
// register reads see all earlier words: the execute stage writes back
// in the same cycle it computes, and the input stage only latches fields.
// reset clears all vector registers and accumulators at once.
module vector_mac_unit_8x16_top
	import vmac_pkg::*;
#(
	parameter int unsigned NUM_VREGS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  op,
	input  logic [3:0]  element_select,
	input  logic [4:0]  src_a_reg,
	input  logic [4:0]  src_b_reg,
	input  logic [4:0]  dest_reg,
	input  logic [63:0] write_data_low,
	input  logic [63:0] write_data_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_low,
	output logic [63:0] result_high
);

	localparam int unsigned IW = (NUM_VREGS > 1) ? $clog2(NUM_VREGS) : 1;

	vec_t vregs_q [NUM_VREGS];
	acc_t accs_q [NLANES];

	logic        v_s1;
	logic [3:0]  op_s1, es_s1;
	logic [IW-1:0] ra_s1, rb_s1, rd_s1;
	logic [127:0] wd_s1;

	vec_t res_vec;
	acc_t acc_nxt [NLANES];
	logic adv;

	// index modulo register count by compare and subtract of shifted multiples
	function automatic logic [IW-1:0] wrap(input logic [4:0] r);
		logic [9:0] t;
		t = {5'd0, r};
		for (int k = 4; k >= 0; k--) begin
			if (t >= 10'(NUM_VREGS << k))
				t = t - 10'(NUM_VREGS << k);
		end
		return t[IW-1:0];
	endfunction

	assign adv = v_s1 && !(out_valid && out_stall);
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op;
			es_s1 <= element_select;
			ra_s1 <= wrap(src_a_reg);
			rb_s1 <= wrap(src_b_reg);
			rd_s1 <= wrap(dest_reg);
			wd_s1 <= {write_data_high, write_data_low};
		end
	end

	vec_t va, vb;
	assign va = vregs_q[ra_s1];
	assign vb = vregs_q[rb_s1];

	for (genvar i = 0; i < NLANES; i++) begin : g_lane
		lane_t lres;
		vmac_lane u_lane (
			.op(op_s1), .a(va[i]), .b(vb[pick_lane(es_s1, 3'(i))]),
			.acc(accs_q[i]), .acc_nxt(acc_nxt[i]), .res(lres)
		);
		always_comb begin
			if (op_s1 == OP_WRITE)
				res_vec[i] = wd_s1[16*i +: 16];
			else if (op_s1 <= OP_MADN)
				res_vec[i] = lres;
			else
				res_vec[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_VREGS; r++)
				vregs_q[r] <= '0;
			for (int l = 0; l < NLANES; l++)
				accs_q[l] <= '0;
		end else if (adv) begin
			if (op_s1 <= OP_WRITE)
				vregs_q[rd_s1] <= res_vec;
			if (op_s1 <= OP_MADN)
				for (int l = 0; l < NLANES; l++)
					accs_q[l] <= acc_nxt[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!(out_valid && out_stall)) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_low  <= res_vec[3:0];
			result_high <= res_vec[7:4];
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");
	a_adv_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("executed word did not reach the result register");
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 > OP_WRITE |=> result_low == 64'd0 && result_high == 64'd0)
		else $error("undefined op gave nonzero result");

endmodule
